// File: sv/mtwe_pkg.sv
package mtwe_pkg;

  // Sensor row geometry
  localparam int SensorCount = 16;
  localparam logic [15:0] EdgeMask = 16'hE007;
  localparam logic [4:0] HalfWindow = 5'd6;
  localparam logic [4:0] CrossStart = 5'd5;
  localparam logic [4:0] CrossEnd = 5'd11;
  localparam logic [4:0] RowEnd = 5'd16;
  localparam logic [5:0] MidHigh = 6'd8;
  localparam logic [5:0] MidLow = 6'd7;
  localparam logic [4:0] LeftLimit = 5'd10;

  // Reciprocal divide: quotient = (n * ceil(2^RecipShift / w)) >> RecipShift
  localparam int RecipShift = 18;
  localparam int RecipWidth = RecipShift + 1;
  localparam int NumerWidth = 14;
  localparam int QuotWidth = 12;
  localparam int ProdWidth = NumerWidth + RecipWidth;

  typedef enum logic [1:0] {
    MODE_STRAIGHT = 2'd0,
    MODE_LEFT     = 2'd1,
    MODE_RIGHT    = 2'd2,
    MODE_SPIN     = 2'd3
  } steer_mode_t;

  typedef struct packed {
    logic [15:0] sensor_bits;
    logic [1:0]  steer_mode;
  } in_item_t;

  typedef struct packed {
    logic signed [12:0] track_error;
    logic               on_track;
    logic [3:0]         window_start;
    logic [4:0]         window_end;
    logic               edge_active;
    logic [4:0]         active_count;
  } out_item_t;

  // First-stage scan of the snapshot
  typedef struct packed {
    logic [15:0] bits;
    logic [1:0]  mode;
    logic        any;
    logic [3:0]  first_idx;
    logic [3:0]  last_idx;
    logic [4:0]  count;
  } scan_t;

  // Selected window and its weight sum
  typedef struct packed {
    logic [3:0]        win_start;
    logic [4:0]        win_end;
    logic [4:0]        width;
    logic signed [6:0] sum;
    logic              edge_active;
  } win_t;

  // Weight of sensor i in sixteenths: 8-i below the center, 7-i above it
  function automatic logic signed [4:0] weight16(input logic [3:0] idx);
    logic [4:0] base;
    base = idx[3] ? 5'd7 : 5'd8;
    return signed'(base - {1'b0, idx});
  endfunction

  // ceil(2^18 / w) for window widths 1..16
  function automatic logic [RecipWidth-1:0] recip(input logic [4:0] w);
    logic [RecipWidth-1:0] r;
    unique case (w)
      5'd2:    r = 19'd131072;
      5'd3:    r = 19'd87382;
      5'd4:    r = 19'd65536;
      5'd5:    r = 19'd52429;
      5'd6:    r = 19'd43691;
      5'd7:    r = 19'd37450;
      5'd8:    r = 19'd32768;
      5'd9:    r = 19'd29128;
      5'd10:   r = 19'd26215;
      5'd11:   r = 19'd23832;
      5'd12:   r = 19'd21846;
      5'd13:   r = 19'd20165;
      5'd14:   r = 19'd18725;
      5'd15:   r = 19'd17477;
      5'd16:   r = 19'd16384;
      default: r = 19'd262144;
    endcase
    return r;
  endfunction

endpackage

// File: sv/mtwe_if.sv
interface mtwe_in_if;
  import mtwe_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mtwe_out_if;
  import mtwe_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/mtwe_window.sv
module mtwe_window (
  input  mtwe_pkg::scan_t scan,
  output mtwe_pkg::win_t  win
);
  import mtwe_pkg::*;

  steer_mode_t       mode;
  logic [4:0]        run_end;
  logic [4:0]        s;
  logic [4:0]        e;
  logic [4:0]        run_width;
  logic [5:0]        mid;
  logic              clear_edges;
  logic [15:0]       stat;
  logic signed [6:0] term [SensorCount];
  logic signed [6:0] lvl1 [8];
  logic signed [6:0] lvl2 [4];
  logic signed [6:0] lvl3 [2];

  assign mode = steer_mode_t'(scan.mode);

  // Find the end of the first run: first inactive sensor above the first active one
  always_comb begin
    run_end = RowEnd;
    for (int i = SensorCount - 1; i >= 0; i--) begin
      if (4'(i) > scan.first_idx && !scan.bits[i]) begin
        run_end = 5'(i);
      end
    end
  end

  // Select the guide window for the turn mode
  always_comb begin
    s = 5'd0;
    e = RowEnd;
    clear_edges = 1'b0;
    run_width = 5'd0;
    mid = 6'd0;
    unique case (mode)
      MODE_STRAIGHT: begin
        s = scan.any ? {1'b0, scan.first_idx} : 5'd0;
        e = scan.any ? run_end : RowEnd;
        run_width = e - s;
        mid = ({1'b0, s} + {1'b0, e}) >> 1;
        if (s == 5'd0 && e == RowEnd) begin
          s = CrossStart;
          e = CrossEnd;
          clear_edges = 1'b1;
        end else if (run_width > HalfWindow) begin
          if (mid > MidHigh) begin
            e = s + HalfWindow;
            clear_edges = 1'b1;
          end else if (mid < MidLow) begin
            s = e - HalfWindow;
            clear_edges = 1'b1;
          end
        end
      end
      MODE_LEFT: begin
        s = scan.any ? {1'b0, scan.first_idx} : 5'd0;
        e = (s <= LeftLimit) ? s + HalfWindow : RowEnd;
      end
      MODE_RIGHT: begin
        e = scan.any ? {1'b0, scan.last_idx} + 5'd1 : RowEnd;
        s = (e >= HalfWindow) ? e - HalfWindow : 5'd0;
      end
      MODE_SPIN: begin
        s = 5'd0;
        e = RowEnd;
      end
      default: begin
        s = 5'd0;
        e = RowEnd;
      end
    endcase
  end

  assign stat = clear_edges ? (scan.bits & ~EdgeMask) : scan.bits;

  // Weight every active sensor inside the window
  always_comb begin
    for (int i = 0; i < SensorCount; i++) begin
      if (stat[i] && 5'(i) >= s && 5'(i) < e) begin
        term[i] = 7'(weight16(4'(i)));
      end else begin
        term[i] = 7'sd0;
      end
    end
  end

  // Sum the weights through a balanced adder tree
  always_comb begin
    for (int i = 0; i < 8; i++) lvl1[i] = term[2*i] + term[2*i+1];
    for (int i = 0; i < 4; i++) lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
    for (int i = 0; i < 2; i++) lvl3[i] = lvl2[2*i] + lvl2[2*i+1];
  end

  assign win.win_start   = s[3:0];
  assign win.win_end     = e;
  assign win.width       = e - s;
  assign win.sum         = lvl3[0] + lvl3[1];
  assign win.edge_active = |(stat & EdgeMask);

endmodule

// File: sv/magnetic_track_window_error_top.sv
// Magnetic guide track error, four register stages.
// A request moves from stage one through stages two and three into the output register.
// Throughput: one request per cycle while result.ready holds; the output register and
// per-stage ready let the pipe keep filling while a result waits. The divide by window
// width is a reciprocal multiply in stage three, which sets the stage depth.
// Reset (synchronous, rst high) clears the stage valid bits; no other state.
module magnetic_track_window_error_top (
  input  logic              clk,
  input  logic              rst,
  mtwe_in_if.sink           sample,
  mtwe_out_if.source        result
);
  import mtwe_pkg::*;

  // Stage valid bits and the ready chain
  logic s1_valid, s2_valid, s3_valid, out_valid;
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage payloads
  scan_t                  s1_scan;
  scan_t                  scan_next;
  win_t                   win;
  win_t                   s2_win;
  logic [4:0]             s2_count;
  logic                   s2_any;
  logic [QuotWidth-1:0]   s3_quot;
  logic                   s3_neg;
  logic [3:0]             s3_start;
  logic [4:0]             s3_end;
  logic                   s3_edge;
  logic [4:0]             s3_count;
  logic                   s3_any;
  out_item_t              out_data;

  logic [5:0]             mag;
  logic [NumerWidth-1:0]  numer;
  logic [ProdWidth-1:0]   prod;
  logic [12:0]            quot_ext;

  assign rdy4 = !out_valid || result.ready;
  assign rdy3 = !s3_valid || rdy4;
  assign rdy2 = !s2_valid || rdy3;
  assign rdy1 = !s1_valid || rdy2;
  assign sample.ready = rdy1;

  // Scan the snapshot: population, first and last active sensor
  always_comb begin
    scan_next.bits = sample.data.sensor_bits;
    scan_next.mode = sample.data.steer_mode;
    scan_next.any = |sample.data.sensor_bits;
    scan_next.count = 5'($countones(sample.data.sensor_bits));
    scan_next.first_idx = 4'd0;
    scan_next.last_idx = 4'd0;
    for (int i = SensorCount - 1; i >= 0; i--) begin
      if (sample.data.sensor_bits[i]) scan_next.first_idx = 4'(i);
    end
    for (int i = 0; i < SensorCount; i++) begin
      if (sample.data.sensor_bits[i]) scan_next.last_idx = 4'(i);
    end
  end

  mtwe_window u_window (
    .scan (s1_scan),
    .win  (win)
  );

  // Scale |sum| by 256 and multiply by the width reciprocal
  assign mag   = s2_win.sum[6] ? 6'(-s2_win.sum) : s2_win.sum[5:0];
  assign numer = {mag, 8'd0};
  assign prod  = ProdWidth'(numer) * ProdWidth'(recip(s2_win.width));

  assign quot_ext = {1'b0, s3_quot};

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) s1_valid  <= sample.valid;
      if (rdy2) s2_valid  <= s1_valid;
      if (rdy3) s3_valid  <= s2_valid;
      if (rdy4) out_valid <= s3_valid;
    end
  end

  // Advance the payloads; hold a stage while its successor stalls
  always_ff @(posedge clk) begin
    if (rdy1) s1_scan <= scan_next;
    if (rdy2) begin
      s2_win   <= win;
      s2_count <= s1_scan.count;
      s2_any   <= s1_scan.any;
    end
    if (rdy3) begin
      s3_quot  <= prod[RecipShift +: QuotWidth];
      s3_neg   <= s2_win.sum[6];
      s3_start <= s2_win.win_start;
      s3_end   <= s2_win.win_end;
      s3_edge  <= s2_win.edge_active;
      s3_count <= s2_count;
      s3_any   <= s2_any;
    end
    if (rdy4) begin
      out_data.track_error  <= s3_neg ? signed'(-quot_ext) : signed'(quot_ext);
      out_data.on_track     <= s3_any;
      out_data.window_start <= s3_start;
      out_data.window_end   <= s3_end;
      out_data.edge_active  <= s3_edge;
      out_data.active_count <= s3_count;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

// File: sv/mtwe_checker.sv
module mtwe_checker (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input mtwe_pkg::out_item_t res_data
);
  import mtwe_pkg::*;

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  // Come out of reset with an empty pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // Tie on_track to the sensor count
  a_on_track: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.on_track == (res_data.active_count != 5'd0)))
    else $error("on_track disagrees with active_count");

  // Report zero error when off track
  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.on_track |-> res_data.track_error == 13'sd0)
    else $error("nonzero error while off track");

  // Keep the window nonempty
  a_window: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> {1'b0, res_data.window_start} < res_data.window_end)
    else $error("empty guide window");

endmodule

bind magnetic_track_window_error_top mtwe_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);
